// ===== sv/lrm_pkg.sv =====
// Shared constants for the line regular-expression matcher.
package lrm_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 32;

  // The pattern registers hold at most this many elements.
  localparam int REG_ELEMENTS = 16;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ELEM_COUNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_START = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_END   = 3'd6;

  // Field widths.
  localparam int BYTE_W      = 8;
  localparam int ECOUNT_W    = 5;
  localparam int OUT_COUNT_W = 32;
  localparam int OUT_TDATA_W = 40;

endpackage

// ===== sv/line_regex_matcher.sv =====
// Top level of the streaming line matcher: registers, handshakes and line counter.
//
// line_regex_matcher takes one text byte per transaction on the in_ stream and, for each
// transaction with in_tlast high (end of line, byte ignored), returns one transaction on the
// out_ stream carrying whether that line matched and the saturating count of matching lines.
// Bytes that do not end a line produce no output. The pattern is a list of up to 16 elements
// written over the cfg_ port: literal bytes, dots (wildcard_mask), stars (repeat_mask), an
// element count (zero matches every line unless both anchors are set) and optional start/end
// anchors; write it only while no line result is pending. Every byte value, zero and newline
// included, is ordinary text. Throughput is one transaction per cycle unless an end of line
// stalls: an accepted item sits in the input register, where the position-set update (closure
// over starred elements plus one advance step) runs, and the state and result registers load
// from it. So the result of an end-of-line transaction passes the input register and then the
// result register before it shows on out_tvalid. The result register lets text bytes keep
// flowing while a result waits; only an end-of-line item stalls behind an untaken result.
module line_regex_matcher #(
  parameter int MAX_ELEMENTS = lrm_pkg::MAX_ELEMENTS_DEF,
  parameter int COUNT_BITS   = lrm_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream. in_tdata: [7:0] text_byte. in_tlast: end_of_line.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lrm_pkg::BYTE_W-1:0]        in_tdata,
  input  logic                              in_tlast,
  // Result stream. out_tdata: [0] line_matched, [32:1] matched_lines, [39:33] zero.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lrm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Configuration write port.
  input  logic                              cfg_wr_en,
  input  logic [lrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Elements actually usable, position-set width and element-count index width.
  localparam int LIM = (MAX_ELEMENTS < lrm_pkg::REG_ELEMENTS) ? MAX_ELEMENTS
                                                               : lrm_pkg::REG_ELEMENTS;
  localparam int NP  = LIM + 1;
  localparam int NW  = $clog2(LIM + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [lrm_pkg::CFG_DATA_W-1:0]     chars_low_r;
  logic [lrm_pkg::CFG_DATA_W-1:0]     chars_high_r;
  logic [lrm_pkg::REG_ELEMENTS-1:0]   wild_r;
  logic [lrm_pkg::REG_ELEMENTS-1:0]   rep_r;
  logic [lrm_pkg::ECOUNT_W-1:0]       ecount_r;
  logic                               anchor_start_r;
  logic                               anchor_end_r;

  // Input register.
  logic                               in_valid_r;
  logic [lrm_pkg::BYTE_W-1:0]         in_byte_r;
  logic                               in_eol_r;

  // Search state.
  logic [NP-1:0]                      active_r;
  logic [NP-1:0]                      active_nxt;
  logic                               found_r;
  logic                               found_nxt;
  logic [COUNT_BITS-1:0]              count_r;
  logic [COUNT_BITS-1:0]              count_nxt;

  // Result register.
  logic                               out_valid_r;
  logic                               out_matched_r;
  logic [lrm_pkg::OUT_COUNT_W-1:0]    out_count_r;

  logic                               proc;
  logic                               matched;
  logic [NW-1:0]                      n_used;
  logic [NP-1:0]                      step_next;
  logic                               step_at_last;

  // The item in the input register is processed unless it is an end of line that would
  // overwrite a result nobody has taken yet.
  assign proc      = in_valid_r && (!in_eol_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;

  // Element counts above what the hardware holds are clamped.
  assign n_used = (ecount_r > lrm_pkg::ECOUNT_W'(LIM)) ? NW'(LIM) : ecount_r[NW-1:0];

  lrm_nfa_step #(
    .LIM (LIM),
    .NP  (NP),
    .NW  (NW)
  ) u_step (
    .active       (active_r),
    .chars        ({chars_high_r, chars_low_r}),
    .wild         (wild_r),
    .rep          (rep_r),
    .n_used       (n_used),
    .text_byte    (in_byte_r),
    .anchor_start (anchor_start_r),
    .next_pos     (step_next),
    .at_last      (step_at_last)
  );

  assign matched = found_r || step_at_last;

  // Next state. An end of line reports and restarts the search; a byte advances it. Without
  // an end anchor, reaching the last position at any point latches the found flag.
  always_comb begin
    active_nxt = active_r;
    found_nxt  = found_r;
    count_nxt  = count_r;
    if (proc) begin
      if (in_eol_r) begin
        active_nxt = {{(NP-1){1'b0}}, 1'b1};
        found_nxt  = 1'b0;
        if (matched && (count_r != COUNT_MAX)) begin
          count_nxt = count_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
      end else begin
        active_nxt = step_next;
        if (!anchor_end_r && step_at_last) begin
          found_nxt = 1'b1;
        end
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r    <= '0;
      chars_high_r   <= '0;
      wild_r         <= '0;
      rep_r          <= '0;
      ecount_r       <= '0;
      anchor_start_r <= 1'b0;
      anchor_end_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lrm_pkg::REG_CHARS_LOW:    chars_low_r    <= cfg_wdata;
        lrm_pkg::REG_CHARS_HIGH:   chars_high_r   <= cfg_wdata;
        lrm_pkg::REG_WILDCARD:     wild_r         <= cfg_wdata[lrm_pkg::REG_ELEMENTS-1:0];
        lrm_pkg::REG_REPEAT:       rep_r          <= cfg_wdata[lrm_pkg::REG_ELEMENTS-1:0];
        lrm_pkg::REG_ELEM_COUNT:   ecount_r       <= cfg_wdata[lrm_pkg::ECOUNT_W-1:0];
        lrm_pkg::REG_ANCHOR_START: anchor_start_r <= cfg_wdata[0];
        lrm_pkg::REG_ANCHOR_END:   anchor_end_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Input payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eol_r  <= in_tlast;
    end
  end

  // Search state and counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= {{(NP-1){1'b0}}, 1'b1};
      found_r  <= 1'b0;
      count_r  <= '0;
    end else begin
      active_r <= active_nxt;
      found_r  <= found_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && in_eol_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; the count is reported in the 32-bit field.
  always_ff @(posedge clk) begin
    if (proc && in_eol_r) begin
      out_matched_r <= matched;
      out_count_r   <= lrm_pkg::OUT_COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(lrm_pkg::OUT_TDATA_W-lrm_pkg::OUT_COUNT_W-1){1'b0}},
                       out_count_r, out_matched_r};

  // Every processed end of line leaves a pending result and a fresh search.
  a_eol_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_eol_r) |=> out_valid_r)
    else $error("end of line processed without a result");

  a_eol_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_eol_r) |=> ((active_r == {{(NP-1){1'b0}}, 1'b1}) && !found_r))
    else $error("search state not restarted after end of line");

  // The matching-line count never goes down outside reset.
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r >= $past(count_r)))
    else $error("matching-line count decreased");

  // A pending matched result implies a nonzero internal count.
  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_matched_r) |-> (count_r != '0))
    else $error("matched line reported with zero count");

endmodule

// ===== sv/lrm_nfa_step.sv =====
// Combinational position-set update: zero-width closure, at-last test and byte advance.
module lrm_nfa_step #(
  parameter int LIM = 16,
  parameter int NP  = LIM + 1,
  parameter int NW  = $clog2(LIM + 1)
) (
  input  logic [NP-1:0]                              active,
  input  logic [lrm_pkg::REG_ELEMENTS*lrm_pkg::BYTE_W-1:0] chars,
  input  logic [lrm_pkg::REG_ELEMENTS-1:0]           wild,
  input  logic [lrm_pkg::REG_ELEMENTS-1:0]           rep,
  input  logic [NW-1:0]                              n_used,
  input  logic [lrm_pkg::BYTE_W-1:0]                 text_byte,
  input  logic                                       anchor_start,
  output logic [NP-1:0]                              next_pos,
  output logic                                       at_last
);

  logic [NP-1:0] rep_u;
  logic [NP-1:0] hit;
  logic [NP-1:0] cur;
  logic [NP-1:0] span;
  logic [NP-1:0] one;
  logic [NP-1:0] adv;

  assign one = {{(NP-1){1'b0}}, 1'b1};

  // Only elements below the element count take part.
  always_comb begin
    rep_u = '0;
    hit   = '0;
    for (int k = 0; k < LIM; k++) begin
      if (k < int'(n_used)) begin
        rep_u[k] = rep[k];
        hit[k]   = wild[k] || (chars[k*lrm_pkg::BYTE_W +: lrm_pkg::BYTE_W] == text_byte);
      end
    end
  end

  // Position k is reached from any active j <= k whose elements j..k-1 are all starred.
  always_comb begin
    cur  = '0;
    span = '0;
    for (int k = 0; k < NP; k++) begin
      for (int j = 0; j <= k; j++) begin
        span = ((one << k) - one) & ~((one << j) - one);
        if (active[j] && (&(rep_u | ~span))) begin
          cur[k] = 1'b1;
        end
      end
    end
  end

  assign at_last = cur[n_used];

  // Starred hits stay, plain hits advance; with no start anchor position 0 stays active.
  always_comb begin
    adv = (cur & hit & rep_u) | ((cur & hit & ~rep_u) << 1);
    if (!anchor_start) begin
      adv[0] = 1'b1;
    end
    next_pos = adv;
  end

endmodule
